// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// expects signals named clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset only
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/alf_pkg.sv =====
// shared types and codes for the linked list block
// no dependencies
package alf_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int LOC_W  = 4;
  localparam int IDX_W  = 4;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID   = 2'd3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [LOC_W-1:0]  loc_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ST_W-1:0]   status_t;

endpackage

// ===== rtl/alf_in_if.sv =====
// command channel of the linked list block
// depends on alf_pkg
interface alf_in_if import alf_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  byte_t node_data;
  loc_t  location;

  modport source (output valid, operation, node_data, location, input ready);
  modport sink   (input valid, operation, node_data, location, output ready);
endinterface

// ===== rtl/alf_out_if.sv =====
// result channel of the linked list block
// depends on alf_pkg
interface alf_out_if import alf_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  idx_t    new_node;
  byte_t   entry_data;
  idx_t    entry_next;
  idx_t    list_head;
  idx_t    free_head;

  modport source (output valid, status, new_node, entry_data, entry_next, list_head,
                  free_head, input ready);
  modport sink   (input valid, status, new_node, entry_data, entry_next, list_head,
                  free_head, output ready);
endinterface

// ===== rtl/array_linked_list_free_list.sv =====
// singly linked list with a free list in one node table; index 0 is null
// cmd (alf_in_if sink) takes insert, delete, read and no-op; rsp (alf_out_if source)
// returns one result per command with status, taken node, entry and both heads.
// a transfer happens on a clock edge with valid and ready both high.
// cmd.ready is high only while the sequencer is idle; one command at a time.
// the link table is read once a cycle. errors found at decode and no-ops go straight
// to the result; an insert takes the free head and links it at the head or after
// the given node; a delete of the head unlinks it directly, other deletes walk from
// the head to the node before it, at most NODE_COUNT + 1 nodes, and fail when the
// walk misses the node; the sequencer passes through idle before the next command.
// the result sits in an output register, so the next command is taken while
// it waits; a further result waits in the sequencer until rsp.ready.
// after rst (synchronous, active high) a clearing pass writes every link and
// rebuilds the free chain 1..NODE_COUNT-1 with cmd.ready low; the list is empty.
// data bytes are not cleared and read as anything until written.
`include "assert_macros.svh"

module array_linked_list_free_list import alf_pkg::*; #(
  parameter int NODE_COUNT = 16
) (
  input  logic     clk,
  input  logic     rst,
  alf_in_if.sink   cmd,
  alf_out_if.source rsp
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int SW = IW + 1;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_INS_A    = 4'd3;
  localparam logic [3:0] S_INS_B    = 4'd4;
  localparam logic [3:0] S_INS_C    = 4'd5;
  localparam logic [3:0] S_DEL_HEAD = 4'd6;
  localparam logic [3:0] S_DEL_WALK = 4'd7;
  localparam logic [3:0] S_DEL_PRED = 4'd8;
  localparam logic [3:0] S_DEL_FREE = 4'd9;
  localparam logic [3:0] S_READ     = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [IW-1:0] next_links [NODE_COUNT];
  byte_t         node_bytes [NODE_COUNT];

  logic [3:0]    state, state_next;
  logic [IW-1:0] init_idx, init_idx_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] free, free_next;
  logic [IW-1:0] node_reg, node_reg_next;
  logic [IW-1:0] cur, cur_next;
  logic [SW-1:0] steps, steps_next;
  op_t           op_reg;
  byte_t         data_reg;
  loc_t          loc_reg;
  status_t       res_status, res_status_next;
  idx_t          res_new_node, res_new_node_next;
  byte_t         res_entry_data, res_entry_data_next;
  idx_t          res_entry_next, res_entry_next_next;
  logic          out_valid;

  logic          nl_we;
  logic [IW-1:0] nl_waddr, nl_wdata, rd_addr, rd_data;
  logic          nb_we;
  byte_t         byte_rd;
  logic [IW-1:0] loc_idx;
  logic          loc_ok;
  logic          accept, load_out;

  assign loc_idx  = IW'(loc_reg);
  assign loc_ok   = 32'(loc_reg) < NODE_COUNT;
  assign cmd.ready = (state == S_IDLE);
  assign accept   = cmd.valid && cmd.ready;
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  // link table: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (nl_we) next_links[nl_waddr] <= nl_wdata;
    rd_data <= next_links[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) node_bytes[node_reg] <= data_reg;
    byte_rd <= node_bytes[loc_idx];
  end

  always_comb begin
    state_next          = state;
    init_idx_next       = init_idx;
    head_next           = head;
    free_next           = free;
    node_reg_next       = node_reg;
    cur_next            = cur;
    steps_next          = steps;
    res_status_next     = res_status;
    res_new_node_next   = res_new_node;
    res_entry_data_next = res_entry_data;
    res_entry_next_next = res_entry_next;
    nl_we    = 1'b0;
    nl_waddr = '0;
    nl_wdata = '0;
    nb_we    = 1'b0;
    rd_addr  = '0;
    case (state)
      S_INIT: begin
        nl_we    = 1'b1;
        nl_waddr = init_idx;
        nl_wdata = (init_idx == IW'(NODE_COUNT - 1)) ? '0 : init_idx + 1'b1;
        init_idx_next = init_idx + 1'b1;
        if (init_idx == IW'(NODE_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        res_status_next     = ST_OK;
        res_new_node_next   = '0;
        res_entry_data_next = '0;
        res_entry_next_next = '0;
        state_next          = S_DONE;
        case (op_reg)
          OP_INSERT: begin
            if (free == '0) begin
              res_status_next = ST_OVERFLOW;
            end else if (!loc_ok) begin
              res_status_next = ST_INVALID;
            end else begin
              node_reg_next = free;
              rd_addr       = free;
              state_next    = S_INS_A;
            end
          end
          OP_DELETE: begin
            if (head == '0) begin
              res_status_next = ST_UNDERFLOW;
            end else if (loc_reg == '0 || !loc_ok) begin
              res_status_next = ST_INVALID;
            end else if (loc_idx == head) begin
              rd_addr    = loc_idx;
              state_next = S_DEL_HEAD;
            end else begin
              cur_next   = head;
              steps_next = '0;
              rd_addr    = head;
              state_next = S_DEL_WALK;
            end
          end
          OP_READ: begin
            if (!loc_ok) begin
              res_status_next = ST_INVALID;
            end else begin
              rd_addr    = loc_idx;
              state_next = S_READ;
            end
          end
          default: begin
            res_status_next = ST_OK;
          end
        endcase
      end
      S_INS_A: begin
        // rd_data is the link of the taken node, the new free head
        free_next = rd_data;
        nb_we     = 1'b1;
        res_new_node_next = IDX_W'(node_reg);
        if (loc_reg == '0) begin
          nl_we      = 1'b1;
          nl_waddr   = node_reg;
          nl_wdata   = head;
          head_next  = node_reg;
          state_next = S_DONE;
        end else begin
          rd_addr    = loc_idx;
          state_next = S_INS_B;
        end
      end
      S_INS_B: begin
        nl_we      = 1'b1;
        nl_waddr   = node_reg;
        nl_wdata   = rd_data;
        state_next = S_INS_C;
      end
      S_INS_C: begin
        nl_we      = 1'b1;
        nl_waddr   = loc_idx;
        nl_wdata   = node_reg;
        state_next = S_DONE;
      end
      S_DEL_HEAD: begin
        head_next  = rd_data;
        nl_we      = 1'b1;
        nl_waddr   = loc_idx;
        nl_wdata   = free;
        free_next  = loc_idx;
        state_next = S_DONE;
      end
      S_DEL_WALK: begin
        // rd_data is the link of cur
        if (cur == '0) begin
          res_status_next = ST_INVALID;
          state_next      = S_DONE;
        end else if (rd_data == loc_idx) begin
          rd_addr    = loc_idx;
          state_next = S_DEL_PRED;
        end else if (steps == SW'(NODE_COUNT)) begin
          res_status_next = ST_INVALID;
          state_next      = S_DONE;
        end else begin
          cur_next   = rd_data;
          steps_next = steps + 1'b1;
          rd_addr    = rd_data;
        end
      end
      S_DEL_PRED: begin
        nl_we      = 1'b1;
        nl_waddr   = cur;
        nl_wdata   = rd_data;
        state_next = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        nl_we      = 1'b1;
        nl_waddr   = loc_idx;
        nl_wdata   = free;
        free_next  = loc_idx;
        state_next = S_DONE;
      end
      S_READ: begin
        res_entry_data_next = byte_rd;
        res_entry_next_next = IDX_W'(rd_data);
        state_next          = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      head      <= '0;
      free      <= IW'(1);
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      init_idx <= init_idx_next;
      head     <= head_next;
      free     <= free_next;
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    node_reg       <= node_reg_next;
    cur            <= cur_next;
    steps          <= steps_next;
    res_status     <= res_status_next;
    res_new_node   <= res_new_node_next;
    res_entry_data <= res_entry_data_next;
    res_entry_next <= res_entry_next_next;
    if (accept) begin
      op_reg   <= cmd.operation;
      data_reg <= cmd.node_data;
      loc_reg  <= cmd.location;
    end
    if (load_out) begin
      rsp.status     <= res_status;
      rsp.new_node   <= res_new_node;
      rsp.entry_data <= res_entry_data;
      rsp.entry_next <= res_entry_next;
      rsp.list_head  <= IDX_W'(head);
      rsp.free_head  <= IDX_W'(free);
    end
  end

  assign rsp.valid = out_valid;

  `ASSERT_RUN(a_walk_bound, (state == S_DEL_WALK) |-> (steps <= SW'(NODE_COUNT)), "walk overrun")
  `ASSERT_RUN(a_insert_node, ((state == S_DONE) && (op_reg == OP_INSERT) && (res_status == ST_OK)) |-> (res_new_node == IDX_W'(node_reg)) && (node_reg != '0), "insert took null node")
  `ASSERT_RUN(a_idle_no_write, (state == S_IDLE) |-> !nl_we, "link write while idle")
  `ASSERT_RUN(a_init_closed, (state == S_INIT) |-> (!cmd.ready && (head == '0) && !out_valid), "command taken during clearing pass")

endmodule

// ===== tb/alf_list_check.sv =====
// result checker for the linked list block: keeps its own node table, predicts
// every result from the command transfers and compares the result transfers
// depends on alf_pkg, alf_in_if and alf_out_if
module alf_list_check import alf_pkg::*; #(
  parameter int NODES = 16
) (
  input  logic clk,
  input  logic rst,
  alf_in_if    cmd,
  alf_out_if   rsp,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t status;
    idx_t    new_node;
    byte_t   entry_data;
    idx_t    entry_next;
    idx_t    list_head;
    idx_t    free_head;
  } outcome_t;

  idx_t     link_tbl [NODES];
  byte_t    byte_tbl [NODES];
  idx_t     list_top;
  idx_t     free_top;
  outcome_t due_results [$];

  initial fail_count = 0;

  // remove a node from the list and push it onto the free chain
  function automatic status_t unlink_node(loc_t loc);
    idx_t cur;
    int   steps;
    if (list_top == '0) return ST_UNDERFLOW;
    if (loc == '0 || int'(loc) >= NODES) return ST_INVALID;
    if (loc == list_top) begin
      list_top = link_tbl[loc];
    end else begin
      cur   = list_top;
      steps = 0;
      // bounded walk, a cyclic list must not hang the search
      while (cur != '0 && link_tbl[cur] != loc && steps < NODES) begin
        cur = link_tbl[cur];
        steps++;
      end
      if (cur == '0 || link_tbl[cur] != loc) return ST_INVALID;
      link_tbl[cur] = link_tbl[loc];
    end
    link_tbl[loc] = free_top;
    free_top      = loc;
    return ST_OK;
  endfunction

  function automatic outcome_t apply_command(op_t op, byte_t data, loc_t loc);
    outcome_t res;
    idx_t     fresh;
    res = '0;
    case (op)
      OP_INSERT: begin
        if (free_top == '0) begin
          res.status = ST_OVERFLOW;
        end else if (int'(loc) >= NODES) begin
          res.status = ST_INVALID;
        end else begin
          fresh           = free_top;
          free_top        = link_tbl[fresh];
          byte_tbl[fresh] = data;
          if (loc == '0) begin
            link_tbl[fresh] = list_top;
            list_top        = fresh;
          end else begin
            // location is taken as given, even a free node or the new one
            link_tbl[fresh] = link_tbl[loc];
            link_tbl[loc]   = fresh;
          end
          res.new_node = fresh;
        end
      end
      OP_DELETE: res.status = unlink_node(loc);
      OP_READ: begin
        if (int'(loc) < NODES) begin
          res.entry_data = byte_tbl[loc];
          res.entry_next = link_tbl[loc];
        end else begin
          res.status = ST_INVALID;
        end
      end
      default: ;
    endcase
    res.list_head = list_top;
    res.free_head = free_top;
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < NODES; i++) link_tbl[i] = (i + 1 < NODES) ? idx_t'(i + 1) : '0;
      list_top = '0;
      free_top = idx_t'(1);
      due_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 8'(want.status), 8'(rsp.status));
          check_field("new_node", 8'(want.new_node), 8'(rsp.new_node));
          check_field("entry_data", want.entry_data, rsp.entry_data);
          check_field("entry_next", 8'(want.entry_next), 8'(rsp.entry_next));
          check_field("list_head", 8'(want.list_head), 8'(rsp.list_head));
          check_field("free_head", 8'(want.free_head), 8'(rsp.free_head));
        end
      end
      if (cmd.valid && cmd.ready)
        due_results.push_back(apply_command(cmd.operation, cmd.node_data, cmd.location));
    end
    pending_count <= due_results.size();
  end

endmodule

// ===== tb/array_linked_list_free_list_tb.sv =====
// top of the linked list testbench: clock, reset, command stimulus, result
// back-pressure and the verdict; checking is done by alf_list_check
// depends on alf_pkg, alf_in_if, alf_out_if, alf_list_check and the block
module array_linked_list_free_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alf_pkg::*;

  localparam int NODES        = 16;
  localparam int RANDOM_ITEMS = 1325;
  localparam int LIMIT        = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    op_t  op;
    loc_t loc;
  } sent_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   cycle_cnt;

  alf_in_if  cmd_if ();
  alf_out_if rsp_if ();

  array_linked_list_free_list #(.NODE_COUNT(NODES)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  alf_list_check #(.NODES(NODES)) list_check (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_if),
    .rsp           (rsp_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // rough view of the table, rebuilt from results, to aim the stimulus
  logic [NODES-1:0] live_nodes;
  logic [NODES-1:0] written_nodes;
  sent_t            sent_q [$];
  int               burst_left;
  bit               fill_bias;
  int               bias_left;
  int               n_op [4];
  int               n_status [4];
  int               n_results;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : timeout
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall modes, plus one long hold-off so the block backs up
  initial begin : receiver
    int  mode;
    int  left;
    int  cyc;
    int  hold_at;
    bit  held;
    rsp_if.ready <= 1'b0;
    mode    = 0;
    left    = 0;
    cyc     = 0;
    held    = 1'b0;
    hold_at = $urandom_range(2000, 3000);
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && cyc >= hold_at) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
          default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_track
    sent_t            done_cmd;
    logic [NODES-1:0] lv;
    logic [NODES-1:0] wr;
    if (!rst && rsp_if.valid && rsp_if.ready && sent_q.size() != 0) begin
      done_cmd = sent_q.pop_front();
      lv = live_nodes;
      wr = written_nodes;
      n_results++;
      n_status[rsp_if.status]++;
      if (rsp_if.new_node != '0) begin
        lv[rsp_if.new_node] = 1'b1;
        wr[rsp_if.new_node] = 1'b1;
      end
      if (done_cmd.op == OP_DELETE && rsp_if.status == ST_OK) lv[done_cmd.loc] = 1'b0;
      live_nodes    <= lv;
      written_nodes <= wr;
    end
  end

  // one command transfer; bursts with valid held high between transfers, gaps between bursts
  task automatic issue(op_t op, byte_t data, loc_t loc);
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.node_data <= data;
    cmd_if.location  <= loc;
    do @(posedge clk); while (!cmd_if.ready);
    sent_q.push_back('{op, loc});
    n_op[op]++;
    burst_left--;
  endtask

  function automatic loc_t pick_node(logic [NODES-1:0] mask);
    int   k;
    loc_t r;
    r = '0;
    if (mask == '0) return r;
    k = $urandom_range(0, $countones(mask) - 1);
    for (int i = 0; i < NODES; i++) begin
      if (mask[i]) begin
        if (k == 0) r = loc_t'(i);
        k--;
      end
    end
    return r;
  endfunction

  // mostly inserts and deletes aimed at live nodes, phases that fill or drain
  task automatic pick_command(output op_t op, output byte_t data, output loc_t loc);
    int               r;
    bit               grow;
    logic [NODES-1:0] readable;
    readable    = written_nodes;
    readable[0] = 1'b0;
    if (bias_left == 0) begin
      fill_bias = !fill_bias;
      bias_left = $urandom_range(20, 80);
    end
    bias_left--;
    r    = $urandom_range(0, 99);
    data = byte_t'($urandom_range(0, 255));
    loc  = loc_t'($urandom_range(0, NODES - 1));
    if (r < 3) begin
      op = OP_INSERT;
    end else if (r < 8) begin
      op = OP_DELETE;
    end else if (r < 11) begin
      op = OP_NOP;
    end else if (r < 25 && readable != '0) begin
      op  = OP_READ;
      loc = pick_node(readable);
    end else begin
      grow = fill_bias ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
      if (grow) begin
        op  = OP_INSERT;
        loc = ($urandom_range(0, 1) == 0 || live_nodes == '0) ? loc_t'(0) : pick_node(live_nodes);
      end else begin
        op = OP_DELETE;
        if (live_nodes != '0) loc = pick_node(live_nodes);
      end
    end
  endtask

  initial begin : stimulus
    op_t   op;
    byte_t data;
    loc_t  loc;
    rst                 <= 1'b1;
    cmd_if.valid        <= 1'b0;
    cmd_if.operation    <= OP_NOP;
    cmd_if.node_data    <= '0;
    cmd_if.location     <= '0;
    live_nodes          <= '0;
    written_nodes       <= '0;
    burst_left = 1;
    fill_bias  = 1'b0;
    bias_left  = 0;
    n_results  = 0;
    foreach (n_op[i]) n_op[i] = 0;
    foreach (n_status[i]) n_status[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, head and mid-list links, bad deletes, walk, full table
    issue(OP_DELETE, 8'h00, 4'd5);
    issue(OP_INSERT, 8'h00, 4'd0);
    issue(OP_INSERT, 8'hFF, 4'd1);
    issue(OP_INSERT, 8'h5A, 4'd0);
    issue(OP_READ,   8'h00, 4'd1);
    issue(OP_DELETE, 8'h00, 4'd0);
    issue(OP_DELETE, 8'h00, 4'd9);
    issue(OP_DELETE, 8'h00, 4'd2);
    issue(OP_DELETE, 8'h00, 4'd3);
    issue(OP_INSERT, 8'hA5, 4'd1);
    for (int i = 0; i < 12; i++) issue(OP_INSERT, 8'($urandom_range(0, 255)), 4'd0);
    issue(OP_INSERT, 8'h81, 4'd14);
    issue(OP_INSERT, 8'h7E, 4'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick_command(op, data, loc);
      issue(op, data, loc);
    end
    cmd_if.valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d insert, %0d delete, %0d read, %0d no-op",
             n_op[OP_INSERT] + n_op[OP_DELETE] + n_op[OP_READ] + n_op[OP_NOP],
             n_op[OP_INSERT], n_op[OP_DELETE], n_op[OP_READ], n_op[OP_NOP]);
    $display("%0d results: %0d ok, %0d overflow, %0d underflow, %0d invalid location",
             n_results, n_status[ST_OK], n_status[ST_OVERFLOW], n_status[ST_UNDERFLOW],
             n_status[ST_INVALID]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
